// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check on every rising edge, ignored while reset is asserted.
`define VBSA_ASSERT(name, clock, reset_n, prop, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) prop) else $error(msg);
// Check on every rising edge, reset included.
`define VBSA_ASSERT_ALWAYS(name, clock, prop, msg) \
    name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define VBSA_ASSERT(name, clock, reset_n, prop, msg)
`define VBSA_ASSERT_ALWAYS(name, clock, prop, msg)
`endif

`endif

// ===== rtl/vbsa_pkg.sv =====
package vbsa_pkg;

    localparam int LEVELS       = 32;
    localparam int LVL_W        = 5;
    localparam int ADDR_W       = 32;
    localparam int HOST_W       = 30;
    localparam int SPARE_W      = 29;
    localparam int PREFIX_W     = 5;
    localparam int PREFIX_MIN   = 2;
    localparam int PREFIX_MAX   = 30;
    localparam int RESET_PREFIX = 24;

    typedef enum logic
    {
        OP_CLEAR = 1'b0,
        OP_ALLOC = 1'b1
    } op_t;

    typedef enum logic
    {
        CFG_BASE_ADDRESS = 1'b0,
        CFG_BASE_PREFIX  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0]
    {
        ST_ALLOC    = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_FULL     = 2'd2,
        ST_CLEARED  = 2'd3
    } status_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_CLEAR,
        S_LOG,
        S_START,
        S_SEARCH,
        S_CHECK,
        S_POP,
        S_PICK,
        S_PUSH,
        S_EMIT
    } state_t;

    typedef enum logic [3:0]
    {
        DP_NOP,
        DP_LOAD,
        DP_LOG,
        DP_SETLVL,
        DP_LVLDEC,
        DP_FOUND,
        DP_JINC,
        DP_CLEAR,
        DP_POP,
        DP_PICK,
        DP_PUSH,
        DP_EMIT
    } dp_op_t;

    typedef enum logic [1:0]
    {
        SEL_LVL,
        SEL_J,
        SEL_DU
    } cnt_sel_t;

    typedef struct packed
    {
        dp_op_t   op;
        cnt_sel_t sel;
        status_t  st;
    } dp_cmd_t;

    typedef struct packed
    {
        logic t_zero;
        logic u_zero;
        logic cnt_nz;
        logic cnt_full;
        logic lvl_one;
        logic j_over;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/vbsa_if.sv =====
interface vbsa_req_if;
    import vbsa_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [HOST_W-1:0] host_count;

    modport source (output valid, output op, output host_count, input ready);
    modport sink   (input valid, input op, input host_count, output ready);
endinterface

interface vbsa_rsp_if;
    import vbsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [ADDR_W-1:0]   subnet_address;
    logic [PREFIX_W-1:0] prefix_length;
    logic [ADDR_W-1:0]   broadcast_address;
    logic [ADDR_W-1:0]   first_host;
    logic [ADDR_W-1:0]   last_host;
    logic [SPARE_W-1:0]  spare_addresses;

    modport source (output valid, output status, output subnet_address, output prefix_length,
                    output broadcast_address, output first_host, output last_host,
                    output spare_addresses, input ready);
    modport sink   (input valid, input status, input subnet_address, input prefix_length,
                    input broadcast_address, input first_host, input last_host,
                    input spare_addresses, output ready);
endinterface

// ===== rtl/vbsa_ctrl.sv =====
`include "assert_macros.svh"

module vbsa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_op,
    output logic              req_ready,
    output vbsa_pkg::dp_cmd_t cmd,
    input  vbsa_pkg::dp_sts_t sts
);
    import vbsa_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    status_t status_reg;
    status_t status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_CLEARED;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd.op      = DP_NOP;
        cmd.sel     = SEL_LVL;
        cmd.st      = status_reg;
        req_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = (req_op == OP_ALLOC) ? S_LOG : S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.op      = DP_CLEAR;
                status_next = ST_CLEARED;
                state_next  = S_EMIT;
            end
            S_LOG:
            begin
                // shift the length counter until the host word is used up
                if (sts.t_zero)
                begin
                    cmd.op     = DP_SETLVL;
                    state_next = S_START;
                end
                else
                begin
                    cmd.op = DP_LOG;
                end
            end
            S_START:
            begin
                if (sts.u_zero)
                begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // walk towards shorter prefixes until a stack holds a block
                cmd.sel = SEL_LVL;
                if (sts.cnt_nz)
                begin
                    cmd.op     = DP_FOUND;
                    state_next = S_CHECK;
                end
                else if (sts.lvl_one)
                begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.op = DP_LVLDEC;
                end
            end
            S_CHECK:
            begin
                // every level that takes a buddy must have room first
                cmd.sel = SEL_J;
                if (sts.j_over)
                begin
                    state_next = S_POP;
                end
                else if (sts.cnt_full)
                begin
                    status_next = ST_FULL;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.op = DP_JINC;
                end
            end
            S_POP:
            begin
                cmd.sel    = SEL_DU;
                cmd.op     = DP_POP;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.op     = DP_PICK;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.sel = SEL_J;
                if (sts.j_over)
                begin
                    status_next = ST_ALLOC;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.op = DP_PUSH;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `VBSA_ASSERT(a_emit_free, clk, rst_n, (cmd.op == DP_EMIT) |-> sts.out_free, "result register overwritten")
    `VBSA_ASSERT(a_accept_start, clk, rst_n, (req_valid && req_ready) |=> (state_reg == S_LOG || state_reg == S_CLEAR), "accepted transaction not started")

endmodule

// ===== rtl/vbsa_datapath.sv =====
`include "assert_macros.svh"

module vbsa_datapath #(
    parameter int FREE_DEPTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  vbsa_pkg::cfg_idx_t                  cfg_index,
    input  logic [vbsa_pkg::ADDR_W-1:0]         cfg_data,
    input  logic [vbsa_pkg::HOST_W-1:0]         host_count,
    input  vbsa_pkg::dp_cmd_t                   cmd,
    output vbsa_pkg::dp_sts_t                   sts,
    vbsa_rsp_if.source                          rsp
);
    import vbsa_pkg::*;

    localparam int CNT_W     = $clog2(FREE_DEPTH + 1);
    localparam int MEM_DEPTH = LEVELS * FREE_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(FREE_DEPTH);
    localparam logic [MEM_AW-1:0] ROW      = MEM_AW'(FREE_DEPTH);

    logic [ADDR_W-1:0]   base_address_reg;
    logic [PREFIX_W-1:0] base_prefix_reg;

    logic [HOST_W-1:0] hosts_reg;
    logic [HOST_W:0]   t_reg;
    logic [LVL_W-1:0]  b_reg;
    logic [LVL_W-1:0]  u_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [LVL_W-1:0]  du_reg;
    logic [LVL_W-1:0]  j_reg;
    logic [ADDR_W-1:0] pick_reg;
    logic [ADDR_W-1:0] rdata_reg;

    logic [CNT_W-1:0]  cnt_reg [LEVELS];
    logic [ADDR_W-1:0] mem [MEM_DEPTH];

    logic                rsp_valid_reg;
    status_t             rsp_status_reg;
    logic [ADDR_W-1:0]   rsp_subnet_reg;
    logic [PREFIX_W-1:0] rsp_prefix_reg;
    logic [ADDR_W-1:0]   rsp_bcast_reg;
    logic [ADDR_W-1:0]   rsp_first_reg;
    logic [ADDR_W-1:0]   rsp_last_reg;
    logic [SPARE_W-1:0]  rsp_spare_reg;

    logic [LVL_W-1:0]    cnt_idx;
    logic [CNT_W-1:0]    cnt_rd;
    logic [CNT_W-1:0]    stack_off;
    logic [MEM_AW-1:0]   stack_addr;
    logic                prefix_ok;
    logic [LVL_W-1:0]    clr_lvl;
    logic [MEM_AW-1:0]   clr_addr;
    logic [ADDR_W-1:0]   clr_base;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [ADDR_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   host_mask;
    logic [ADDR_W-1:0]   bcast;
    logic [ADDR_W-1:0]   spare_full;
    logic                is_alloc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
            base_prefix_reg  <= PREFIX_W'(RESET_PREFIX);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_ADDRESS: base_address_reg <= cfg_data;
                CFG_BASE_PREFIX:  base_prefix_reg  <= cfg_data[PREFIX_W-1:0];
                default:          base_prefix_reg  <= base_prefix_reg;
            endcase
        end
    end

    // one count read port, steered by the sequencer
    always_comb
    begin
        case (cmd.sel)
            SEL_LVL: cnt_idx = lvl_reg;
            SEL_J:   cnt_idx = j_reg;
            SEL_DU:  cnt_idx = du_reg;
            default: cnt_idx = lvl_reg;
        endcase
    end

    assign cnt_rd     = cnt_reg[cnt_idx];
    assign stack_off  = (cmd.op == DP_POP) ? cnt_rd - CNT_W'(1) : cnt_rd;
    assign stack_addr = MEM_AW'(cnt_idx) * ROW + MEM_AW'(stack_off);

    assign prefix_ok = (base_prefix_reg >= PREFIX_W'(PREFIX_MIN))
                       && (base_prefix_reg <= PREFIX_W'(PREFIX_MAX));
    assign clr_lvl   = base_prefix_reg - LVL_W'(1);
    assign clr_addr  = MEM_AW'(clr_lvl) * ROW;
    assign clr_base  = base_address_reg
                       & ({ADDR_W{1'b1}} << (6'd32 - {1'b0, base_prefix_reg}));

    assign mem_we    = ((cmd.op == DP_CLEAR) && prefix_ok) || (cmd.op == DP_PUSH);
    assign mem_waddr = (cmd.op == DP_CLEAR) ? clr_addr : stack_addr;
    // upper buddy: set the lowest bit of the prefix of this level
    assign mem_wdata = (cmd.op == DP_CLEAR) ? clr_base
                       : (pick_reg | ({1'b1, {(ADDR_W-1){1'b0}}} >> j_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.op == DP_POP)
        begin
            rdata_reg <= mem[stack_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                DP_CLEAR:
                begin
                    // empty every level, seed the base level if its prefix is valid
                    for (int i = 0; i < LEVELS; i++)
                    begin
                        cnt_reg[i] <= (prefix_ok && (LVL_W'(i) == clr_lvl)) ? CNT_W'(1) : '0;
                    end
                end
                DP_POP:  cnt_reg[cnt_idx] <= cnt_rd - CNT_W'(1);
                DP_PUSH: cnt_reg[cnt_idx] <= cnt_rd + CNT_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                hosts_reg <= host_count;
                t_reg     <= {1'b0, host_count} + (HOST_W+1)'(1);
                b_reg     <= '0;
            end
            DP_LOG:
            begin
                t_reg <= t_reg >> 1;
                b_reg <= b_reg + LVL_W'(1);
            end
            DP_SETLVL:
            begin
                u_reg   <= LVL_W'(31) - b_reg;
                lvl_reg <= LVL_W'(31) - b_reg;
            end
            DP_LVLDEC: lvl_reg <= lvl_reg - LVL_W'(1);
            DP_FOUND:
            begin
                du_reg <= lvl_reg;
                j_reg  <= lvl_reg + LVL_W'(1);
            end
            DP_JINC:   j_reg <= j_reg + LVL_W'(1);
            DP_PICK:
            begin
                pick_reg <= rdata_reg;
                j_reg    <= du_reg + LVL_W'(1);
            end
            DP_PUSH:   j_reg <= j_reg + LVL_W'(1);
            default: ;
        endcase
    end

    assign host_mask  = (ADDR_W'(1) << b_reg) - ADDR_W'(1);
    assign bcast      = pick_reg | host_mask;
    assign spare_full = (host_mask + ADDR_W'(1)) - (ADDR_W'(hosts_reg) + ADDR_W'(2));
    assign is_alloc   = (cmd.st == ST_ALLOC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.op == DP_EMIT)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_EMIT)
        begin
            rsp_status_reg <= cmd.st;
            rsp_subnet_reg <= is_alloc ? pick_reg : '0;
            rsp_prefix_reg <= is_alloc ? u_reg + LVL_W'(1) : '0;
            rsp_bcast_reg  <= is_alloc ? bcast : '0;
            rsp_first_reg  <= is_alloc ? (pick_reg | ADDR_W'(1)) : '0;
            rsp_last_reg   <= is_alloc ? (bcast ^ ADDR_W'(1)) : '0;
            rsp_spare_reg  <= is_alloc ? spare_full[SPARE_W-1:0] : '0;
        end
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.status            = rsp_status_reg;
    assign rsp.subnet_address    = rsp_subnet_reg;
    assign rsp.prefix_length     = rsp_prefix_reg;
    assign rsp.broadcast_address = rsp_bcast_reg;
    assign rsp.first_host        = rsp_first_reg;
    assign rsp.last_host         = rsp_last_reg;
    assign rsp.spare_addresses   = rsp_spare_reg;

    assign sts.t_zero   = (t_reg == '0);
    assign sts.u_zero   = (u_reg == '0);
    assign sts.cnt_nz   = (cnt_rd != '0);
    assign sts.cnt_full = (cnt_rd >= CNT_FULL);
    assign sts.lvl_one  = (lvl_reg == LVL_W'(1));
    assign sts.j_over   = (j_reg > u_reg);
    assign sts.out_free = !rsp_valid_reg || rsp.ready;

    `VBSA_ASSERT(a_push_room, clk, rst_n, (cmd.op == DP_PUSH) |-> (cnt_rd < CNT_FULL), "push onto a full free stack")
    `VBSA_ASSERT(a_pop_nonempty, clk, rst_n, (cmd.op == DP_POP) |-> (cnt_rd != '0), "pop from an empty free stack")
    `VBSA_ASSERT_ALWAYS(a_err_zero, clk, (rsp.valid && rsp.status != ST_ALLOC) |-> (rsp.subnet_address == '0 && rsp.prefix_length == '0), "refused transaction carries an address")

endmodule

// ===== rtl/vlsm_buddy_subnet_allocator.sv =====
// Buddy allocator of IPv4 subnets. A clear transaction (op 0) loads the free stacks with the
// configured base network when its prefix lies in 2 to 30; an allocate transaction (op 1)
// returns a block of 2^b addresses, b = ceil(log2(host_count + 2)), from the top of a free
// stack, splitting a larger block and stacking its upper buddies where needed; send the
// largest requests first. One result per transaction. An allocate finds the bit length
// of host_count + 1 (the length counter takes one bit a cycle), searches the levels for a
// non-empty stack, checks the smaller levels for room, pops the block and pushes the
// buddies; the single read port on the per-level counts visits one level at a time, and
// no level walk covers more than 30 levels. One transaction is worked on at a time; a new one
// is taken while the previous result waits in the output register. The user must write
// configuration only while idle; the block does not enforce it. It applies at the next clear.
module vlsm_buddy_subnet_allocator #(
    parameter int FREE_DEPTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  vbsa_pkg::cfg_idx_t          cfg_index,
    input  logic [vbsa_pkg::ADDR_W-1:0] cfg_data,
    vbsa_req_if.sink                    req,
    vbsa_rsp_if.source                  rsp
);
    import vbsa_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    vbsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    vbsa_datapath #(
        .FREE_DEPTH (FREE_DEPTH)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .host_count (req.host_count),
        .cmd        (cmd),
        .sts        (sts),
        .rsp        (rsp)
    );

endmodule
